### src/terminal_cursor_escape_parser_defines.svh
// Assertion macros for the terminal cursor escape parser.
// Included by the RTL files that carry checks; no other dependencies.
`ifndef TERMINAL_CURSOR_ESCAPE_PARSER_DEFINES_SVH
`define TERMINAL_CURSOR_ESCAPE_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define TCEP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TCEP_ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define TCEP_ASSERT(label, clk, rstn, prop, msg)
`define TCEP_ASSERT_NEVER(label, clk, rstn, expr, msg)
`endif
`endif

### src/tcep_pkg.sv
// Package for the terminal cursor escape parser: character codes, result kinds,
// default argument count. No dependencies.
`default_nettype none

package tcep_pkg;

    localparam int NUM_ARGS_DEF = 3;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_LBRK  = 8'h5B;  // '['
    localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] CH_MOVE  = 8'h48;  // 'H'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
    localparam logic [7:0] CH_UP_X  = 8'h58;  // 'X'
    localparam logic [7:0] CH_LO_A  = 8'h61;  // 'a'
    localparam logic [7:0] CH_LO_X  = 8'h78;  // 'x'

    typedef enum logic
    {
        ACT_DRAW = 1'b0,
        ACT_MOVE = 1'b1
    } action_t;

endpackage

`default_nettype wire

### src/terminal_cursor_escape_parser.sv
// Terminal cursor escape parser: draws plain bytes, decodes ESC [ a ; b H moves.
// Depends on tcep_pkg and terminal_cursor_escape_parser_defines.svh.
//
//  channel | dir | tdata (low bit up)                    | tuser
//  s_*     | in  | char_code[7:0]                        | -
//  m_*     | out | glyph[7:0], col_pos[7:0], row_pos[7:0] | action
//
// One byte per cycle unless stalled as below: a byte is held in the input register,
// is decoded, and any result it yields lands in the result register.
// A byte that yields no result moves on even while a result waits downstream;
// a byte that yields one waits in the input register until the result slot frees.
// rst_n clears the escape state, argument index and accumulators.
`default_nettype none

`include "terminal_cursor_escape_parser_defines.svh"

module terminal_cursor_escape_parser
    import tcep_pkg::*;
#(
    parameter int NUM_ARGS = NUM_ARGS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // char_code[7:0]
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [23:0] m_tdata,   // glyph[7:0], col_pos[15:8], row_pos[23:16]
    output      logic        m_tuser    // action
);

    localparam int SEL_W = (NUM_ARGS > 1) ? $clog2(NUM_ARGS) : 1;
    localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(NUM_ARGS - 1);

    // input register
    logic             in_valid_reg;
    logic [7:0]       in_char_reg;

    // parser state
    logic                          esc_reg, esc_next;
    logic [SEL_W-1:0]              arg_sel_reg, arg_sel_next;
    logic [NUM_ARGS-1:0][7:0]      arg_vals_reg, arg_vals_next;

    // result register
    logic             out_valid_reg;
    action_t          out_action_reg;
    logic [7:0]       out_glyph_reg;
    logic [7:0]       out_col_reg;
    logic [7:0]       out_row_reg;

    logic             produce;
    logic             advance;
    logic             fire;
    action_t          res_action;
    logic [7:0]       res_glyph;
    logic [7:0]       res_col;
    logic [7:0]       res_row;
    logic [7:0]       cur_arg;
    logic [7:0]       acc;
    logic [7:0]       digit_off;

    assign cur_arg   = arg_vals_reg[arg_sel_reg];
    assign digit_off = in_char_reg - CH_ZERO;
    // arg * 10 + digit, mod 256
    assign acc = {cur_arg[4:0], 3'b000} + {cur_arg[6:0], 1'b0} + {4'd0, digit_off[3:0]};

    assign produce = (in_char_reg != CH_NUL) &&
                     (esc_reg ? (in_char_reg == CH_MOVE) : (in_char_reg != CH_ESC));
    assign advance = !out_valid_reg || m_tready || !produce;
    assign fire    = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        esc_next      = esc_reg;
        arg_sel_next  = arg_sel_reg;
        arg_vals_next = arg_vals_reg;
        res_action    = ACT_DRAW;
        res_glyph     = in_char_reg;
        res_col       = 8'd0;
        res_row       = 8'd0;
        if (in_char_reg != CH_NUL)
        begin
            if (!esc_reg)
            begin
                if (in_char_reg == CH_ESC)
                begin
                    esc_next = 1'b1;
                end
            end
            else
            begin
                case (in_char_reg)
                    CH_LBRK:
                    begin
                        arg_sel_next     = '0;
                        arg_vals_next[0] = 8'd0;
                        arg_vals_next[1] = 8'd0;
                    end
                    CH_MOVE:
                    begin
                        esc_next   = 1'b0;
                        res_action = ACT_MOVE;
                        res_glyph  = 8'd0;
                        res_col    = arg_vals_reg[0];
                        res_row    = arg_vals_reg[1];
                    end
                    CH_SEMI:
                    begin
                        if (arg_sel_reg != SEL_LAST)
                        begin
                            arg_sel_next = arg_sel_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        if (in_char_reg inside {[CH_ZERO:CH_NINE]})
                        begin
                            for (int i = 0; i < NUM_ARGS; i++)
                            begin
                                if (SEL_W'(i) == arg_sel_reg)
                                begin
                                    arg_vals_next[i] = acc;
                                end
                            end
                        end
                        else if (in_char_reg inside {[CH_UP_A:CH_UP_X], [CH_LO_A:CH_LO_X]})
                        begin
                            esc_next = 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            esc_reg       <= 1'b0;
            arg_sel_reg   <= '0;
            arg_vals_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                esc_reg      <= esc_next;
                arg_sel_reg  <= arg_sel_next;
                arg_vals_reg <= arg_vals_next;
            end

            if (fire && produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
        end
        if (fire && produce)
        begin
            out_action_reg <= res_action;
            out_glyph_reg  <= res_glyph;
            out_col_reg    <= res_col;
            out_row_reg    <= res_row;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_action_reg;
    assign m_tdata  = {out_row_reg, out_col_reg, out_glyph_reg};

    `TCEP_ASSERT_NEVER(a_sel_range, clk, rst_n, arg_sel_reg > SEL_LAST, "argument index past last")
    `TCEP_ASSERT(a_move_ends_esc, clk, rst_n, (fire && produce && esc_reg) |=> !esc_reg, "move did not leave escape mode")
    `TCEP_ASSERT(a_stall_cause, clk, rst_n, !s_tready |-> (in_valid_reg && out_valid_reg && produce), "input stalled without a blocked result")
    `TCEP_ASSERT(a_draw_nonzero, clk, rst_n, (m_tvalid && m_tuser == ACT_DRAW) |-> (m_tdata[7:0] != 8'd0 && m_tdata[7:0] != CH_ESC), "drawn glyph is zero or escape")

endmodule

`default_nettype wire

### test/terminal_cursor_escape_parser_tb.sv
// Testbench for terminal_cursor_escape_parser: random and directed byte streams in,
// draw and cursor-move words checked against an in-bench predictor.
// Depends on tcep_pkg and the terminal_cursor_escape_parser RTL.
module terminal_cursor_escape_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcep_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int TAIL_CYCLES     = 10;
    localparam int RANDOM_ITEMS    = 800;

    typedef struct packed
    {
        action_t    action;
        logic [7:0] glyph;
        logic [7:0] col_pos;
        logic [7:0] row_pos;
    } disp_word_t;

    // Tracks the parser state and queues the word, if any, that each accepted byte should produce.
    class cursor_scoreboard;
        bit          in_esc;
        int unsigned sel;
        logic [7:0]  args [NUM_ARGS_DEF];
        disp_word_t  expected_words [$];
        int unsigned mismatches;

        function new();
            in_esc = 1'b0;
            sel = 0;
            foreach (args[i])
                args[i] = 8'd0;
            mismatches = 0;
        endfunction

        function void decode_char(logic [7:0] c);
            disp_word_t w;
            w = '0;
            if (c == CH_NUL)
                return;
            if (!in_esc)
            begin
                if (c == CH_ESC)
                    in_esc = 1'b1;
                else
                begin
                    w.action = ACT_DRAW;
                    w.glyph = c;
                    expected_words.push_back(w);
                end
                return;
            end
            if (c == CH_LBRK)
            begin
                sel = 0;
                args[0] = 8'd0;
                args[1] = 8'd0;
            end
            else if (c == CH_MOVE)
            begin
                in_esc = 1'b0;
                w.action = ACT_MOVE;
                w.col_pos = args[0];
                w.row_pos = args[1];
                expected_words.push_back(w);
            end
            else if (c == CH_SEMI)
            begin
                if (sel + 1 < NUM_ARGS_DEF)
                    sel++;
            end
            else if (c >= CH_ZERO && c <= CH_NINE)
                args[sel] = 8'(args[sel] * 10 + (c - CH_ZERO));
            else if ((c >= CH_UP_A && c <= CH_UP_X) || (c >= CH_LO_A && c <= CH_LO_X))
                in_esc = 1'b0;
        endfunction

        function void report(string what, disp_word_t exp_w, disp_word_t got);
            if (mismatches < 10)
                $display("%s: exp act=%0d glyph=%0d col=%0d row=%0d, got act=%0d glyph=%0d col=%0d row=%0d",
                         what, exp_w.action, exp_w.glyph, exp_w.col_pos, exp_w.row_pos,
                         got.action, got.glyph, got.col_pos, got.row_pos);
            mismatches++;
        endfunction

        function void check_word(disp_word_t got);
            disp_word_t exp_w;
            if (expected_words.size() == 0)
            begin
                report("unexpected word", '0, got);
                return;
            end
            exp_w = expected_words.pop_front();
            if (got.action != exp_w.action || got.glyph != exp_w.glyph ||
                got.col_pos != exp_w.col_pos || got.row_pos != exp_w.row_pos)
                report("mismatch", exp_w, got);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;      // char_code[7:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;             // glyph[7:0], col_pos[15:8], row_pos[23:16]
    logic        m_tuser;             // action

    cursor_scoreboard board;
    logic [7:0]       char_stream [$];

    terminal_cursor_escape_parser u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        disp_word_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.action = action_t'(m_tuser);
            got.glyph = m_tdata[7:0];
            got.col_pos = m_tdata[15:8];
            got.row_pos = m_tdata[23:16];
            board.check_word(got);
        end
    end

    // Receiver: random ready pattern, with one long hold-off early on so the
    // input side backs up.
    initial
    begin
        int unsigned rounds;
        int unsigned mode;
        int unsigned k;
        rounds = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 9);
            if (rounds == 12)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (mode < 3)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else
            begin
                for (k = 0; k < 8; k++)
                begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(1, 4)) @(posedge clk);
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
            rounds++;
        end
    end

    task automatic push_digits(int unsigned count);
        repeat (count)
            char_stream.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic send_char(logic [7:0] c);
        s_tvalid <= 1'b1;
        s_tdata <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.decode_char(c);
    endtask

    initial
    begin
        int unsigned idx;
        int unsigned burst;
        int unsigned gap;
        int unsigned kind;
        int unsigned nargs;
        int unsigned a;
        int unsigned drain;
        logic [7:0]  term;

        board = new();

        // Directed: draw extremes, nulls in both modes, ESC inside escape, wrapping
        // arguments, a saturating argument index, move without '[', silent enders.
        char_stream = '{CH_UP_A, 8'hFF, 8'h01, CH_NUL, CH_ESC, CH_NUL, CH_ESC, CH_LBRK,
                        "2", "5", "5", CH_SEMI, "1", "7", CH_SEMI, CH_SEMI, CH_SEMI,
                        "9", CH_MOVE, CH_ESC, CH_MOVE, CH_ESC, "Y", "z", "5", CH_LO_X,
                        "Z", CH_ESC, CH_LBRK, "9", "9", "9", CH_SEMI, "3", "0", "0",
                        CH_UP_X, CH_ESC, CH_LBRK, CH_MOVE};

        while (char_stream.size() < RANDOM_ITEMS + 40)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 12)
            begin
                // move-like escape sequence with random content, not always well-formed
                char_stream.push_back(CH_ESC);
                if ($urandom_range(0, 7) != 0)
                    char_stream.push_back(CH_LBRK);
                nargs = $urandom_range(0, 4);
                for (a = 0; a < nargs; a++)
                begin
                    push_digits(($urandom_range(0, 7) == 0) ? $urandom_range(4, 5)
                                                           : $urandom_range(0, 3));
                    if (a + 1 < nargs || $urandom_range(0, 5) == 0)
                        char_stream.push_back(CH_SEMI);
                    if ($urandom_range(0, 9) == 0)
                        char_stream.push_back(($urandom_range(0, 1) != 0) ?
                                              CH_NUL : 8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 4) != 0)
                    term = CH_MOVE;
                else if ($urandom_range(0, 1) != 0)
                    term = CH_UP_A + 8'($urandom_range(0, 23));
                else
                    term = CH_LO_A + 8'($urandom_range(0, 23));
                char_stream.push_back(term);
            end
            else if (kind < 17)
            begin
                repeat ($urandom_range(1, 8))
                    char_stream.push_back(8'($urandom_range(1, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    char_stream.push_back(8'($urandom_range(0, 255)));
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idx = 0;
        while (idx < char_stream.size())
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && idx < char_stream.size())
            begin
                send_char(char_stream[idx]);
                idx++;
                burst--;
            end
            gap = $urandom_range(0, 5);
            if (gap > 0 && idx < char_stream.size())
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;

        drain = 0;
        while (board.expected_words.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.expected_words.size() != 0)
        begin
            $display("%0d expected words never arrived", board.expected_words.size());
            board.mismatches += board.expected_words.size();
        end

        if (board.mismatches == 0)
            $display("terminal_cursor_escape_parser_tb: done, clean");
        else
            $display("terminal_cursor_escape_parser_tb: done, errors");
        $finish;
    end

    initial
    begin
        #400000;
        $display("terminal_cursor_escape_parser_tb: done, errors");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/tcep_pkg.sv
src/terminal_cursor_escape_parser.sv
test/terminal_cursor_escape_parser_tb.sv
